// ----- sv/midpoint_circle_point_generator_assert.svh -----
// assertion macros for the midpoint circle point generator
// used by the top level only; expects i_clk and i_rst_n in scope
`ifndef MIDPOINT_CIRCLE_POINT_GENERATOR_ASSERT_SVH
`define MIDPOINT_CIRCLE_POINT_GENERATOR_ASSERT_SVH

// same-cycle implication, idle during reset
`define MCPG_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, idle during reset
`define MCPG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/mcpg_pkg.sv -----
// shared types and constants of the midpoint circle point generator
// no dependencies
package mcpg_pkg;

    // request kinds carried on the input tuser
    localparam logic REQ_START   = 1'b0;
    localparam logic REQ_ADVANCE = 1'b1;

    // decision term constants of the midpoint rule
    localparam int DT_INIT      = 3;
    localparam int DT_STEP_DOWN = 10;
    localparam int DT_STEP_FLAT = 6;

    // result point fields and mirror count
    localparam int POINT_W    = 16;
    localparam int NUM_POINTS = 8;

    // job queue depth between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    typedef struct packed {
        logic [POINT_W-1:0] y;
        logic [POINT_W-1:0] x;
    } t_point;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// ----- sv/mcpg_front.sv -----
// front end: accepts requests, keeps the circle state and steps the midpoint rule
// depends on mcpg_pkg; pushes one job per producing request into mcpg_queue
module mcpg_front
    import mcpg_pkg::*;
#(
    parameter int COORD_BITS  = 15,
    parameter int RADIUS_BITS = 10,
    parameter int JOB_W       = 2 * COORD_BITS + 2 * (RADIUS_BITS + 1) + 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic                   i_req_type,
    input  logic [COORD_BITS-1:0]  i_center_x,
    input  logic [COORD_BITS-1:0]  i_center_y,
    input  logic [RADIUS_BITS-1:0] i_radius,
    input  t_q_status              i_q_status,
    output logic                   o_push,
    output logic [JOB_W-1:0]       o_job
);

    localparam int OW = RADIUS_BITS + 1;
    localparam int DW = RADIUS_BITS + 4;

    logic [COORD_BITS-1:0] r_cx, n_cx;
    logic [COORD_BITS-1:0] r_cy, n_cy;
    logic [OW-1:0]         r_x, n_x;
    logic [OW-1:0]         r_y, n_y;
    logic signed [DW-1:0]  r_d, n_d;
    logic                  r_active, n_active;

    logic                  w_accept;
    logic                  w_end;
    logic [OW-1:0]         w_x1;
    logic [OW-1:0]         w_y1;
    logic signed [OW:0]    w_diff;
    logic signed [DW-1:0]  w_r_ext;

    assign o_ready  = !i_q_status.full;
    assign w_accept = i_valid && o_ready;

    always_comb begin
        n_cx     = r_cx;
        n_cy     = r_cy;
        n_x      = r_x;
        n_y      = r_y;
        n_d      = r_d;
        n_active = r_active;
        o_push   = 1'b0;
        w_end    = 1'b0;
        w_x1     = r_x + OW'(1);
        w_y1     = r_y;
        w_diff   = '0;
        w_r_ext  = signed'(DW'(i_radius));
        if (w_accept) begin
            if (i_req_type == REQ_START) begin
                n_cx     = i_center_x;
                n_cy     = i_center_y;
                n_x      = '0;
                n_y      = OW'(i_radius);
                n_d      = DW'(DT_INIT) - (w_r_ext <<< 1);
                w_end    = (i_radius == '0);
                n_active = !w_end;
                o_push   = 1'b1;
            end else if (r_active) begin
                if (r_d > 0) begin
                    w_y1   = r_y - OW'(1);
                    w_diff = signed'({1'b0, w_x1}) - signed'({1'b0, w_y1});
                    n_d    = r_d + (DW'(w_diff) <<< 2) + DW'(DT_STEP_DOWN);
                end else begin
                    n_d    = r_d + (signed'(DW'(w_x1)) <<< 2) + DW'(DT_STEP_FLAT);
                end
                n_x      = w_x1;
                n_y      = w_y1;
                w_end    = (w_y1 < w_x1);
                n_active = !w_end;
                o_push   = 1'b1;
            end
        end
    end

    assign o_job = {w_end, n_y, n_x, n_cy, n_cx};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else begin
            r_active <= n_active;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cx <= n_cx;
        r_cy <= n_cy;
        r_x  <= n_x;
        r_y  <= n_y;
        r_d  <= n_d;
    end

endmodule

// ----- sv/mcpg_queue.sv -----
// short job queue that decouples the front end from the point emitter
// depends on mcpg_pkg for its depth and status type
module mcpg_queue
    import mcpg_pkg::*;
#(
    parameter int WIDTH = 55
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output t_q_status        o_status
);

    logic [WIDTH-1:0] r_mem [Q_DEPTH];
    logic [Q_AW-1:0]  r_wr_ptr;
    logic [Q_AW-1:0]  r_rd_ptr;
    logic [Q_AW:0]    r_count;
    logic             w_wr;
    logic             w_rd;

    assign o_status.full  = (r_count == (Q_AW + 1)'(Q_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign w_wr   = i_push && !o_status.full;
    assign w_rd   = i_pop && !o_status.empty;
    assign o_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= r_wr_ptr + Q_AW'(1);
            end
            if (w_rd) begin
                r_rd_ptr <= r_rd_ptr + Q_AW'(1);
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + (Q_AW + 1)'(1);
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - (Q_AW + 1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ----- sv/mcpg_back.sv -----
// back end: expands one job into its mirrored points, one point per cycle
// while the output is not stalled; depends on mcpg_pkg; drives the registered result stream
module mcpg_back
    import mcpg_pkg::*;
#(
    parameter int COORD_BITS  = 15,
    parameter int RADIUS_BITS = 10,
    parameter int JOB_W       = 2 * COORD_BITS + 2 * (RADIUS_BITS + 1) + 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [JOB_W-1:0] i_job,
    input  t_q_status        i_q_status,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output t_point           o_point,
    output logic             o_last,
    output logic             o_end
);

    localparam int OW = RADIUS_BITS + 1;
    localparam int CW = ((COORD_BITS > OW) ? COORD_BITS : OW) + 2;

    logic [COORD_BITS-1:0] w_cx, w_cy;
    logic [OW-1:0]         w_ox, w_oy;
    logic                  w_jend;
    logic signed [CW-1:0]  w_cxs, w_cys, w_oxs, w_oys;
    logic signed [CW-1:0]  w_cx_mx, w_cx_my, w_cy_mx, w_cy_my;
    logic                  w_a, w_b, w_c, w_d;
    logic [NUM_POINTS-1:0] w_mask;

    // mirrored sums of the job being expanded
    logic [POINT_W-1:0]    r_cx_px, r_cx_mx, r_cx_py, r_cx_my;
    logic [POINT_W-1:0]    r_cy_px, r_cy_mx, r_cy_py, r_cy_my;
    logic                  r_jend;
    logic [NUM_POINTS-1:0] r_mask;
    logic                  r_busy;

    logic                  r_out_valid;
    t_point                r_point;
    logic                  r_last;
    logic                  r_end;

    t_point                w_pts [NUM_POINTS];
    t_point                w_sel;
    logic [NUM_POINTS-1:0] w_first;
    logic [NUM_POINTS-1:0] w_rest;
    logic                  w_out_adv;
    logic                  w_emit;
    logic                  w_finish;

    assign {w_jend, w_oy, w_ox, w_cy, w_cx} = i_job;

    assign w_cxs   = signed'(CW'(w_cx));
    assign w_cys   = signed'(CW'(w_cy));
    assign w_oxs   = signed'(CW'(w_ox));
    assign w_oys   = signed'(CW'(w_oy));
    assign w_cx_mx = w_cxs - w_oxs;
    assign w_cx_my = w_cxs - w_oys;
    assign w_cy_mx = w_cys - w_oxs;
    assign w_cy_my = w_cys - w_oys;
    assign w_a     = w_cx_mx > 0;
    assign w_b     = w_cy_my > 0;
    assign w_c     = w_cy_mx > 0;
    assign w_d     = w_cx_my > 0;
    assign w_mask  = {w_d, w_b, w_c && w_d, w_c, w_a && w_b, w_a, 1'b1, 1'b1};

    always_comb begin
        w_pts[0] = '{x: r_cx_px, y: r_cy_py};
        w_pts[1] = '{x: r_cx_py, y: r_cy_px};
        w_pts[2] = '{x: r_cx_mx, y: r_cy_py};
        w_pts[3] = '{x: r_cx_mx, y: r_cy_my};
        w_pts[4] = '{x: r_cx_py, y: r_cy_mx};
        w_pts[5] = '{x: r_cx_my, y: r_cy_mx};
        w_pts[6] = '{x: r_cx_px, y: r_cy_my};
        w_pts[7] = '{x: r_cx_my, y: r_cy_px};
    end

    assign w_first = r_mask & (~r_mask + NUM_POINTS'(1));
    assign w_rest  = r_mask & ~w_first;

    always_comb begin
        w_sel = '0;
        for (int k = 0; k < NUM_POINTS; k++) begin
            w_sel = w_sel | (w_pts[k] & {(2 * POINT_W){w_first[k]}});
        end
    end

    assign w_out_adv = !r_out_valid || i_ready;
    assign w_emit    = r_busy && w_out_adv;
    assign w_finish  = w_emit && (w_rest == '0);
    assign o_pop     = (!r_busy || w_finish) && !i_q_status.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
            end else if (w_finish) begin
                r_busy <= 1'b0;
            end
            if (w_out_adv) begin
                r_out_valid <= r_busy;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cx_px <= POINT_W'(w_cxs + w_oxs);
            r_cx_mx <= POINT_W'(w_cx_mx);
            r_cx_py <= POINT_W'(w_cxs + w_oys);
            r_cx_my <= POINT_W'(w_cx_my);
            r_cy_px <= POINT_W'(w_cys + w_oxs);
            r_cy_mx <= POINT_W'(w_cy_mx);
            r_cy_py <= POINT_W'(w_cys + w_oys);
            r_cy_my <= POINT_W'(w_cy_my);
            r_jend  <= w_jend;
            r_mask  <= w_mask;
        end else if (w_emit) begin
            r_mask  <= w_rest;
        end
        if (w_emit) begin
            r_point <= w_sel;
            r_last  <= (w_rest == '0);
            r_end   <= (w_rest == '0) && r_jend;
        end
    end

    assign o_valid = r_out_valid;
    assign o_point = r_point;
    assign o_last  = r_last;
    assign o_end   = r_end;

endmodule

// ----- sv/midpoint_circle_point_generator.sv -----
// midpoint circle point generator: front end, job queue and point emitter
// path: job queue entry, emitter job registers, then the output point register
// throughput: one point per cycle while the output is not stalled; a job yields 2 to 8
//   mirrored points; the front takes a request per cycle while the queue has room
// reset: synchronous active-low i_rst_n clears tracing, the queue and the output stage
// depends on mcpg_pkg, mcpg_front, mcpg_queue, mcpg_back and the assertion macro header
`include "midpoint_circle_point_generator_assert.svh"

module midpoint_circle_point_generator
    import mcpg_pkg::*;
#(
    parameter int COORD_BITS  = 15,
    parameter int RADIUS_BITS = 10
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request stream
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // tdata from bit 0: center_x, center_y, radius, zero fill to whole bytes
    input  logic [((2 * COORD_BITS + RADIUS_BITS + 7) / 8) * 8 - 1:0] i_s_axis_tdata,
    // tuser: req_type
    input  logic                 i_s_axis_tuser,
    // point stream
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // tdata from bit 0: point_x, point_y
    output logic [2*POINT_W-1:0] o_m_axis_tdata,
    // tlast: last_of_item
    output logic                 o_m_axis_tlast,
    // tuser: circle_end
    output logic                 o_m_axis_tuser
);

    // job word: center x, center y, offset x, offset y, end flag
    localparam int JOB_W = 2 * COORD_BITS + 2 * (RADIUS_BITS + 1) + 1;

    logic [COORD_BITS-1:0]  w_center_x;
    logic [COORD_BITS-1:0]  w_center_y;
    logic [RADIUS_BITS-1:0] w_radius;

    logic                   w_push;
    logic                   w_pop;
    logic [JOB_W-1:0]       w_job_in;
    logic [JOB_W-1:0]       w_job_out;
    t_q_status              w_q;
    t_point                 w_point;

    // unpack the request fields
    assign w_center_x = i_s_axis_tdata[COORD_BITS-1:0];
    assign w_center_y = i_s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
    assign w_radius   = i_s_axis_tdata[2*COORD_BITS+RADIUS_BITS-1:2*COORD_BITS];

    // front end starts a trace, or steps the midpoint rule once per taken step request while tracing
    mcpg_front #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS),
        .JOB_W       (JOB_W)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_axis_tvalid),
        .o_ready    (o_s_axis_tready),
        .i_req_type (i_s_axis_tuser),
        .i_center_x (w_center_x),
        .i_center_y (w_center_y),
        .i_radius   (w_radius),
        .i_q_status (w_q),
        .o_push     (w_push),
        .o_job      (w_job_in)
    );

    // jobs wait here while the emitter is still expanding earlier ones
    mcpg_queue #(
        .WIDTH (JOB_W)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_data   (w_job_in),
        .i_pop    (w_pop),
        .o_data   (w_job_out),
        .o_status (w_q)
    );

    // emitter walks the point mask, one point per transaction
    mcpg_back #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS),
        .JOB_W       (JOB_W)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job      (w_job_out),
        .i_q_status (w_q),
        .o_pop      (w_pop),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_point    (w_point),
        .o_last     (o_m_axis_tlast),
        .o_end      (o_m_axis_tuser)
    );

    assign o_m_axis_tdata = w_point;

    // the end of a circle is always the last point of its request
    `MCPG_ASSERT_IMPLIES(a_end_is_last, o_m_axis_tvalid && o_m_axis_tuser, o_m_axis_tlast, "circle end without last")
    // the emitter only takes a job that is there
    `MCPG_ASSERT_IMPLIES(a_pop_not_empty, w_pop, !w_q.empty, "pop from empty job queue")
    // the front never loses a job to a full queue
    `MCPG_ASSERT_IMPLIES(a_push_not_full, w_push, !w_q.full, "push into full job queue")
    // a job pushed into an empty queue is visible next cycle
    `MCPG_ASSERT_NEXT(a_push_lands, w_push && w_q.empty, !w_q.empty, "pushed job missing")

endmodule

// ----- sim/mcpg_checker.sv -----
`timescale 1ns / 100ps
// scoreboard for the midpoint circle point generator: predicts the points of each request
// and compares them with the point stream; depends on mcpg_pkg only
module mcpg_checker
    import mcpg_pkg::*;
#(
    parameter int COORD_BITS  = 15,
    parameter int RADIUS_BITS = 10
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request channel as seen at the block
    input  logic                 i_req_valid,
    input  logic                 i_req_ready,
    // from bit 0: center_x, center_y, radius
    input  logic [((2 * COORD_BITS + RADIUS_BITS + 7) / 8) * 8 - 1:0] i_req_data,
    input  logic                 i_req_kind,
    // point channel as seen at the block
    input  logic                 i_pt_valid,
    input  logic                 i_pt_ready,
    // from bit 0: point_x, point_y
    input  logic [2*POINT_W-1:0] i_pt_data,
    input  logic                 i_pt_last,
    input  logic                 i_pt_end,
    output int                   o_outstanding,
    output int                   o_fail_count,
    output int                   o_points_seen
);

    typedef struct packed {
        logic [POINT_W-1:0] col;
        logic [POINT_W-1:0] row;
        logic               item_last;
        logic               circle_done;
    } t_circle_point;

    t_circle_point         expected_points[$];

    // predicted circle state
    logic [COORD_BITS-1:0] hub_x;
    logic [COORD_BITS-1:0] hub_y;
    int                    step_x;
    int                    step_y;
    int                    decision;
    logic                  tracing;

    int                    fail_count;
    int                    points_seen;

    function automatic t_circle_point plot(input int px, input int py);
        t_circle_point p;
        p.col         = px[POINT_W-1:0];
        p.row         = py[POINT_W-1:0];
        p.item_last   = 1'b0;
        p.circle_done = 1'b0;
        return p;
    endfunction

    // eight-way mirror of the current offsets, dropping points whose subtracted coordinate is not above zero
    task automatic queue_mirrors(input logic ending);
        t_circle_point pts [NUM_POINTS];
        int            n;
        int            cx;
        int            cy;
        n  = 0;
        cx = int'(hub_x);
        cy = int'(hub_y);
        pts[n] = plot(cx + step_x, cy + step_y);
        n      = n + 1;
        pts[n] = plot(cx + step_y, cy + step_x);
        n      = n + 1;
        if (cx - step_x > 0) begin
            pts[n] = plot(cx - step_x, cy + step_y);
            n      = n + 1;
            if (cy - step_y > 0) begin
                pts[n] = plot(cx - step_x, cy - step_y);
                n      = n + 1;
            end
        end
        if (cy - step_x > 0) begin
            pts[n] = plot(cx + step_y, cy - step_x);
            n      = n + 1;
            if (cx - step_y > 0) begin
                pts[n] = plot(cx - step_y, cy - step_x);
                n      = n + 1;
            end
        end
        if (cy - step_y > 0) begin
            pts[n] = plot(cx + step_x, cy - step_y);
            n      = n + 1;
        end
        if (cx - step_y > 0) begin
            pts[n] = plot(cx - step_y, cy + step_x);
            n      = n + 1;
        end
        pts[n-1].item_last   = 1'b1;
        pts[n-1].circle_done = ending;
        for (int i = 0; i < n; i++) expected_points.insert(expected_points.size(), pts[i]);
    endtask

    task automatic predict_request(input logic kind, input logic [$bits(i_req_data)-1:0] data);
        if (kind == REQ_START) begin
            hub_x    = data[COORD_BITS-1:0];
            hub_y    = data[2*COORD_BITS-1:COORD_BITS];
            step_x   = 0;
            step_y   = int'(data[2*COORD_BITS+RADIUS_BITS-1:2*COORD_BITS]);
            decision = DT_INIT - 2 * step_y;
            tracing  = (step_y != 0);
            queue_mirrors(step_y == 0);
        end else if (tracing) begin
            step_x = step_x + 1;
            if (decision > 0) begin
                step_y   = step_y - 1;
                decision = decision + 4 * (step_x - step_y) + DT_STEP_DOWN;
            end else begin
                decision = decision + 4 * step_x + DT_STEP_FLAT;
            end
            if (step_y < step_x) tracing = 1'b0;
            queue_mirrors(step_y < step_x);
        end
    endtask

    task automatic check_point();
        t_circle_point want;
        logic [POINT_W-1:0] got_x;
        logic [POINT_W-1:0] got_y;
        got_x = i_pt_data[POINT_W-1:0];
        got_y = i_pt_data[2*POINT_W-1:POINT_W];
        points_seen = points_seen + 1;
        if (expected_points.size() == 0) begin
            $error("unexpected point x %0d y %0d", got_x, got_y);
            fail_count = fail_count + 1;
        end else begin
            want = expected_points.pop_front();
            if (got_x !== want.col) begin
                $error("point_x expected %0d got %0d", want.col, got_x);
                fail_count = fail_count + 1;
            end
            if (got_y !== want.row) begin
                $error("point_y expected %0d got %0d", want.row, got_y);
                fail_count = fail_count + 1;
            end
            if (i_pt_last !== want.item_last) begin
                $error("last_of_item expected %0b got %0b", want.item_last, i_pt_last);
                fail_count = fail_count + 1;
            end
            if (i_pt_end !== want.circle_done) begin
                $error("circle_end expected %0b got %0b", want.circle_done, i_pt_end);
                fail_count = fail_count + 1;
            end
        end
    endtask

    initial begin
        fail_count  = 0;
        points_seen = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hub_x    = '0;
            hub_y    = '0;
            step_x   = 0;
            step_y   = 0;
            decision = 0;
            tracing  = 1'b0;
            expected_points.delete();
        end else begin
            // retire first so a point never matches a request taken on the same edge
            if (i_pt_valid && i_pt_ready) check_point();
            if (i_req_valid && i_req_ready) predict_request(i_req_kind, i_req_data);
        end
        o_outstanding <= expected_points.size();
        o_fail_count  <= fail_count;
        o_points_seen <= points_seen;
    end

endmodule

// ----- sim/tb_midpoint_circle_point_generator.sv -----
`timescale 1ns / 100ps
// top testbench of the midpoint circle point generator: directed and random circle traces
// under several pacing phases; depends on mcpg_pkg, the block and mcpg_checker
module tb_midpoint_circle_point_generator;
    import mcpg_pkg::*;

    localparam int COORD_BITS   = 15;
    localparam int RADIUS_BITS  = 10;
    localparam int REQ_W        = ((2 * COORD_BITS + RADIUS_BITS + 7) / 8) * 8;
    localparam int COORD_MAX    = (1 << COORD_BITS) - 1;
    localparam int RADIUS_MAX   = (1 << RADIUS_BITS) - 1;
    localparam int RANDOM_ITEMS = 125;
    localparam int LONG_HOLD    = 300;     // receiver hold-off in cycles
    localparam int SETTLE       = 24;      // quiet cycles after the last point
    localparam int CYCLE_LIMIT  = 200000;

    logic               i_clk;
    logic               i_rst_n = 1'b0;

    // request side, driven by the stimulus process
    logic               s_valid = 1'b0;
    logic [REQ_W-1:0]   s_data  = '0;      // center_x, center_y, radius from bit 0
    logic               s_user  = REQ_START;
    logic               s_ready;

    // point side, tready driven by the receiver process
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [2*POINT_W-1:0] m_data;          // point_x, point_y from bit 0
    logic               m_last;
    logic               m_user;

    // pacing knobs, in percent
    int                 src_idle_pct   = 0;
    int                 sink_stall_pct = 0;

    // long receiver hold-off, requested once by the stimulus
    logic               hold_trigger = 1'b0;
    logic               hold_taken   = 1'b0;
    int                 hold_left    = 0;

    int                 outstanding;
    int                 fail_count;
    int                 points_seen;
    int                 cycle_count  = 0;
    int                 starts_sent  = 0;
    int                 steps_sent   = 0;

    midpoint_circle_point_generator #(
        .COORD_BITS (COORD_BITS),
        .RADIUS_BITS(RADIUS_BITS)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(s_valid),
        .o_s_axis_tready(s_ready),
        .i_s_axis_tdata (s_data),
        .i_s_axis_tuser (s_user),
        .o_m_axis_tvalid(m_valid),
        .i_m_axis_tready(m_ready),
        .o_m_axis_tdata (m_data),
        .o_m_axis_tlast (m_last),
        .o_m_axis_tuser (m_user)
    );

    mcpg_checker #(
        .COORD_BITS (COORD_BITS),
        .RADIUS_BITS(RADIUS_BITS)
    ) i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (s_valid),
        .i_req_ready  (s_ready),
        .i_req_data   (s_data),
        .i_req_kind   (s_user),
        .i_pt_valid   (m_valid),
        .i_pt_ready   (m_ready),
        .i_pt_data    (m_data),
        .i_pt_last    (m_last),
        .i_pt_end     (m_user),
        .o_outstanding(outstanding),
        .o_fail_count (fail_count),
        .o_points_seen(points_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // watchdog: a hung handshake ends the run here
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // receiver: one long hold-off on request, otherwise random stalls at the phase rate
    always @(posedge i_clk) begin
        if (hold_trigger && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left  <= LONG_HOLD;
            m_ready    <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // number of step requests until the trace of radius r reports its end
    function automatic int circle_steps(input int r);
        int x;
        int y;
        int d;
        int n;
        x = 0;
        y = r;
        d = DT_INIT - 2 * r;
        n = 0;
        if (r == 0) return 0;
        while (y >= x) begin
            x = x + 1;
            if (d > 0) begin
                y = y - 1;
                d = d + 4 * (x - y) + DT_STEP_DOWN;
            end else begin
                d = d + 4 * x + DT_STEP_FLAT;
            end
            n = n + 1;
        end
        return n;
    endfunction

    // one request transaction, preceded by random idle cycles
    task automatic send_request(input logic kind, input int cx, input int cy, input int r);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_user  <= kind;
        s_data  <= {r[RADIUS_BITS-1:0], cy[COORD_BITS-1:0], cx[COORD_BITS-1:0]};
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        if (kind == REQ_START) starts_sent = starts_sent + 1;
        else steps_sent = steps_sent + 1;
    endtask

    // step request with random content in the unused fields
    task automatic send_step();
        send_request(REQ_ADVANCE, $urandom_range(COORD_MAX), $urandom_range(COORD_MAX),
                     $urandom_range(RADIUS_MAX));
    endtask

    // stop offering and wait until every predicted point has been taken
    task automatic drain_points();
        s_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    task automatic set_pacing(input int phase);
        case (phase)
            0: begin
                src_idle_pct   <= 0;
                sink_stall_pct <= 0;
            end
            1: begin
                src_idle_pct   <= 67;
                sink_stall_pct <= 0;
            end
            2: begin
                src_idle_pct   <= 0;
                sink_stall_pct <= 67;
            end
            default: begin
                src_idle_pct   <= 30;
                sink_stall_pct <= 30;
            end
        endcase
    endtask

    initial begin
        int counted;
        int phase;
        int cur_phase;
        int r;
        int cx;
        int cy;
        int steps;
        int n_steps;
        int cap;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part, no idling
        send_step();                                   // step while idle: ignored
        send_request(REQ_START, 0, 0, 0);              // zero radius, all at the center
        send_step();
        send_request(REQ_START, COORD_MAX, COORD_MAX, RADIUS_MAX);   // largest coordinates
        repeat (3) send_step();
        send_request(REQ_START, 0, 0, RADIUS_MAX);     // restart mid-trace, mirrors dropped
        repeat (2) send_step();
        send_request(REQ_START, 1, 1, 1);              // tiny circle touching zero
        send_step();
        send_step();                                   // after the end: ignored
        send_request(REQ_START, COORD_MAX, 0, 2);
        repeat (circle_steps(2)) send_step();
        send_request(REQ_START, 3, 2, 5);
        repeat (circle_steps(5)) send_step();
        send_request(REQ_START, 0, COORD_MAX, 7);
        repeat (2) send_step();
        drain_points();

        // random part: mostly whole traces of small circles, some abandoned ones
        counted   = 0;
        cur_phase = -1;
        while (counted < RANDOM_ITEMS) begin
            phase = counted * 4 / RANDOM_ITEMS;
            if (phase != cur_phase) begin
                drain_points();
                set_pacing(phase);
                if (phase == 0) hold_trigger <= 1'b1;  // fills the block while unpaced
                cur_phase = phase;
            end

            r = ($urandom_range(7) == 0) ? $urandom_range(RADIUS_MAX) : $urandom_range(24, 1);
            if ($urandom_range(3) == 0) begin
                // near the low edges so mirrored points get dropped
                cx = $urandom_range(r + 2);
                cy = $urandom_range(r + 2);
            end else begin
                cx = $urandom_range(COORD_MAX);
                cy = $urandom_range(COORD_MAX);
            end
            steps   = circle_steps(r);
            n_steps = steps;
            if (r > 40 || $urandom_range(4) == 0) begin
                cap     = (steps < 10) ? steps : 10;
                n_steps = $urandom_range(cap);
            end

            send_request(REQ_START, cx, cy, r);
            repeat (n_steps) send_step();
            counted = counted + 1 + n_steps;
            // a few stray steps after a finished trace
            if (n_steps == steps && $urandom_range(3) == 0) begin
                repeat ($urandom_range(2, 1)) send_step();
            end
        end

        drain_points();
        repeat (SETTLE) @(posedge i_clk);

        $display("covered %0d circle starts and %0d step requests over four pacing phases,",
                 starts_sent, steps_sent);
        $display("%0d points compared against the prediction", points_seen);
        if (fail_count == 0 && outstanding == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+sv
sv/mcpg_pkg.sv
sv/mcpg_front.sv
sv/mcpg_queue.sv
sv/mcpg_back.sv
sv/midpoint_circle_point_generator.sv
sim/mcpg_checker.sv
sim/tb_midpoint_circle_point_generator.sv
